/* design/mps_pkg.sv */
// Shared types and constants of the min/product stack.
`default_nettype none
package mps_pkg;

	// Number of entries the stack can hold.
	localparam int unsigned DEPTH = 64;
	// Width of the entry counter, able to hold DEPTH itself.
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	// Fixed field widths.
	localparam int unsigned DATA_W = 32;
	localparam int unsigned DEPTH_FIELD_W = 7;
	localparam int unsigned STATUS_W = 2;
	// Result payload: 106 bits of fields padded to 112.
	localparam int unsigned M_TDATA_W = 112;
	localparam int unsigned M_FIELDS_W = 3 * DATA_W + DEPTH_FIELD_W + 1 + STATUS_W;

	// Minimum reported for an empty stack.
	localparam logic [DATA_W-1:0] EMPTY_MIN = '1;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	// One stack entry: the value and the minimum and product at or below it.
	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic [DATA_W-1:0] minimum;
		logic [DATA_W-1:0] product;
	} entry_t;

	// Shift control broadcast along the chain of cells.
	typedef struct packed {
		logic shift_down;
		logic shift_up;
	} cell_ctrl_t;

endpackage
`default_nettype wire

/* design/mps_push_unit.sv */
// Builds the entry for a push from the new value and the entry below it.
`default_nettype none
module mps_push_unit (
	input  wire logic [mps_pkg::DATA_W-1:0] value,
	input  wire mps_pkg::entry_t            below,
	input  wire logic                       has_below,
	output mps_pkg::entry_t                 entry
);

	logic [2*mps_pkg::DATA_W-1:0] full_product;
	logic                         keep_below_min;

	// Low half of the product is the same for signed and unsigned operands.
	assign full_product   = {{mps_pkg::DATA_W{1'b0}}, value} *
	                        {{mps_pkg::DATA_W{1'b0}}, below.product};
	assign keep_below_min = $signed(value) >= $signed(below.minimum);

	// With nothing below, the minimum and product are the value itself.
	always_comb begin
		entry.value = value;
		if (has_below) begin
			entry.minimum = keep_below_min ? below.minimum : value;
			entry.product = full_product[mps_pkg::DATA_W-1:0];
		end else begin
			entry.minimum = value;
			entry.product = value;
		end
	end

endmodule
`default_nettype wire

/* design/mps_cell.sv */
// One storage cell of the stack chain; it shifts towards or away from the top.
`default_nettype none
module mps_cell (
	input  wire logic                 clk,
	input  wire mps_pkg::cell_ctrl_t  ctrl,
	input  wire mps_pkg::entry_t      from_above,
	input  wire mps_pkg::entry_t      from_below,
	output mps_pkg::entry_t           entry
);

	mps_pkg::entry_t entry_q;

	// A push moves every entry one place down, a pop one place up.
	always_ff @(posedge clk) begin
		if (ctrl.shift_down) begin
			entry_q <= from_above;
		end else if (ctrl.shift_up) begin
			entry_q <= from_below;
		end
	end

	assign entry = entry_q;

endmodule
`default_nettype wire

/* design/min_product_stack_core.sv */
// Top level of the min/product stack: a chain of cells with the top in cell 0.
// Timing: the result of an item is registered and presented in the cycle after its transfer.
// Throughput: one push or pop per cycle while the result channel is not stalled; the
// multiply of the push unit feeding cell 0 and the result register sets the cycle.
// Reset: arst_n clears the entry count and the result valid flag; the cells
// themselves are not cleared, as only entries below the count are ever read.
`default_nettype none
module min_product_stack_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Input channel.
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [mps_pkg::DATA_W-1:0]    s_tdata, // [31:0] push_value
	input  wire logic [0:0]                    s_tuser, // [0] opcode
	// Result channel.
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// [31:0] top_value, [63:32] running_minimum, [95:64] running_product,
	// [102:96] stack_depth, [103] is_empty, [105:104] status, [111:106] zero
	output logic [mps_pkg::M_TDATA_W-1:0]      m_tdata
);

	logic                          accept;
	logic                          is_pop;
	logic                          full;
	logic                          empty;
	logic                          do_push;
	logic                          do_pop;
	logic [mps_pkg::CNT_W-1:0]     count_q;
	logic [mps_pkg::CNT_W-1:0]     count_next;
	mps_pkg::status_t              status_next;
	mps_pkg::entry_t               new_entry;
	mps_pkg::entry_t               top_next;
	mps_pkg::entry_t               chain [mps_pkg::DEPTH];
	mps_pkg::cell_ctrl_t           ctrl;
	logic                          m_valid_q;
	logic [mps_pkg::M_FIELDS_W-1:0] m_fields_q;
	logic [mps_pkg::M_FIELDS_W-1:0] fields_next;

	// Handshake: the result register frees up when its transfer completes.
	assign s_tready = !m_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign is_pop   = (s_tuser[0] == mps_pkg::OP_POP);
	assign full     = (count_q == mps_pkg::CNT_W'(mps_pkg::DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = accept && !is_pop && !full;
	assign do_pop   = accept && is_pop && !empty;

	assign ctrl.shift_down = do_push;
	assign ctrl.shift_up   = do_pop;

	// New entry for a push, derived from the current top.
	mps_push_unit u_push_unit (
		.value     (s_tdata),
		.below     (chain[0]),
		.has_below (!empty),
		.entry     (new_entry)
	);

	// The chain of cells; cell 0 holds the top of the stack.
	for (genvar i = 0; i < mps_pkg::DEPTH; i++) begin : g_cell
		mps_pkg::entry_t above;
		mps_pkg::entry_t below;
		if (i == 0) begin : g_first
			assign above = new_entry;
		end else begin : g_inner_above
			assign above = chain[i-1];
		end
		if (i == mps_pkg::DEPTH - 1) begin : g_last
			assign below = '0;
		end else begin : g_inner_below
			assign below = chain[i+1];
		end
		mps_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.from_above (above),
			.from_below (below),
			.entry      (chain[i])
		);
	end

	// Count, status and top entry after the operation.
	always_comb begin
		count_next  = count_q;
		status_next = mps_pkg::ST_OK;
		top_next    = chain[0];
		if (do_push) begin
			count_next = count_q + mps_pkg::CNT_W'(1);
			top_next   = new_entry;
		end else if (do_pop) begin
			count_next = count_q - mps_pkg::CNT_W'(1);
			top_next   = chain[1];
		end
		if (!is_pop && full) begin
			status_next = mps_pkg::ST_OVERFLOW;
		end else if (is_pop && empty) begin
			status_next = mps_pkg::ST_UNDERFLOW;
		end
	end

	// Result fields, with the empty-stack values substituted.
	always_comb begin
		if (count_next == '0) begin
			fields_next = {status_next, 1'b1, mps_pkg::DEPTH_FIELD_W'(count_next),
			               {mps_pkg::DATA_W{1'b0}}, mps_pkg::EMPTY_MIN,
			               {mps_pkg::DATA_W{1'b0}}};
		end else begin
			fields_next = {status_next, 1'b0, mps_pkg::DEPTH_FIELD_W'(count_next),
			               top_next.product, top_next.minimum, top_next.value};
		end
	end

	// Entry counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_next;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (accept) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			m_fields_q <= fields_next;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(mps_pkg::M_TDATA_W - mps_pkg::M_FIELDS_W){1'b0}}, m_fields_q};

	// The entry count never exceeds the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= mps_pkg::CNT_W'(mps_pkg::DEPTH))
		else $error("entry count above capacity");

	// A refused push leaves the count unchanged.
	a_overflow_hold: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !is_pop && full |=> count_q == $past(count_q))
		else $error("overflowing push changed the count");

	// An accepted pop on a non-empty stack lowers the count by one.
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop |=> count_q == $past(count_q) - mps_pkg::CNT_W'(1))
		else $error("pop did not lower the count");

	// An empty result reports depth zero and the empty minimum.
	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[103] |-> m_tdata[102:96] == '0 &&
		m_tdata[63:32] == mps_pkg::EMPTY_MIN)
		else $error("empty result with wrong fields");

	// An underflow is only reported for an empty stack.
	a_underflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[105:104] == mps_pkg::ST_UNDERFLOW |-> m_tdata[103])
		else $error("underflow reported on a non-empty stack");

endmodule
`default_nettype wire
